/* src/sdae_pkg.sv */
// Package with the widths, character codes, types and sequencer states of the decimal emitter.
package sdae_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int NDIG        = ((VALUE_WIDTH * 77) >> 8) + 1;
  localparam int BCD_W       = 4 * NDIG;
  localparam int DIG_CNT_W   = $clog2(NDIG + 1);
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int LEN_W       = 5;
  localparam int MAX_CHARS   = 20;
  localparam int CHAR_W      = 8;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  typedef logic [BCD_W-1:0] bcd_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_NORM = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

/* src/sdae_bcd_step.sv */
// One shift-and-add-3 step of the binary to BCD conversion over all decimal digits.
module sdae_bcd_step
  import sdae_pkg::*;
(
  input  bcd_t bcd_in,
  input  logic bit_in,
  output bcd_t bcd_out
);

  bcd_t adj;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_in[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_in[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_in[4*i +: 4];
      end
    end
  end

  assign bcd_out = {adj[BCD_W-2:0], bit_in};

endmodule

/* src/signed_decimal_ascii_emitter_top.sv */
// Top level of the signed decimal emitter: sequencer, magnitude, conversion and character output.
//
//   channel | direction | beat contents
//   in_     | slave     | tdata[63:0] signed_value
//   out_    | master    | tdata[7:0] ascii_char, tdata[12:8] total_length; tlast is_last
//
// A value is accepted only while the sequencer is idle. The single BCD step unit then runs
// once per magnitude bit (VALUE_WIDTH, 64), leading zero digits are dropped at one per cycle (up to NDIG-1),
// and the characters leave at one per cycle while the receiver keeps accepting them.
// Reset clears the sequencer and the output valid. A stalled output holds its beat and the
// sequencer waits; the next value may be accepted while the last character is still pending.
module signed_decimal_ascii_emitter_top
  import sdae_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [63:0] signed_value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] ascii_char, [12:8] total_length
  output logic                   out_tlast
);

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  bcd_t                   bcd_r, bcd_nxt, bcd_step;
  logic                   neg_r, neg_nxt;
  logic                   minus_r, minus_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]   ndig_r, ndig_nxt;
  logic [LEN_W-1:0]       total_r, total_nxt;
  logic [LEN_W-1:0]       left_r, left_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [LEN_W-1:0]       out_len_r, out_len_nxt;

  logic [VALUE_WIDTH-1:0] in_val;
  logic                   in_neg;
  logic [LEN_W:0]         tot_sum;
  logic                   load;

  sdae_bcd_step u_step (
    .bcd_in  (bcd_r),
    .bit_in  (mag_r[VALUE_WIDTH-1]),
    .bcd_out (bcd_step)
  );

  assign in_val    = in_tdata[VALUE_WIDTH-1:0];
  assign in_neg    = in_val[VALUE_WIDTH-1];
  assign in_tready = (state_r == ST_IDLE);
  assign tot_sum   = (LEN_W+1)'(ndig_r) + (LEN_W+1)'(neg_r);
  assign load      = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    minus_nxt     = minus_r;
    bit_cnt_nxt   = bit_cnt_r;
    ndig_nxt      = ndig_r;
    total_nxt     = total_r;
    left_nxt      = left_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_len_nxt   = out_len_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          neg_nxt     = in_neg;
          mag_nxt     = in_neg ? (~in_val + 1'b1) : in_val;
          bcd_nxt     = '0;
          bit_cnt_nxt = BIT_CNT_W'(VALUE_WIDTH);
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt     = bcd_step;
        mag_nxt     = {mag_r[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == BIT_CNT_W'(1)) begin
          ndig_nxt  = DIG_CNT_W'(NDIG);
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (bcd_r[BCD_W-1 -: 4] == 4'd0 && ndig_r > DIG_CNT_W'(1)) begin
          bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
          ndig_nxt = ndig_r - 1'b1;
        end else begin
          if (tot_sum > (LEN_W+1)'(MAX_CHARS)) begin
            total_nxt = LEN_W'(MAX_CHARS);
          end else begin
            total_nxt = tot_sum[LEN_W-1:0];
          end
          left_nxt  = total_nxt;
          minus_nxt = neg_r;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = total_r;
          out_last_nxt  = (left_r == LEN_W'(1));
          if (minus_r) begin
            out_char_nxt = ASCII_MINUS;
            minus_nxt    = 1'b0;
          end else begin
            out_char_nxt = ASCII_ZERO + CHAR_W'(bcd_r[BCD_W-1 -: 4]);
            bcd_nxt      = {bcd_r[BCD_W-5:0], 4'd0};
          end
          left_nxt = left_r - 1'b1;
          if (left_r == LEN_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    neg_r      <= neg_nxt;
    minus_r    <= minus_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    ndig_r     <= ndig_nxt;
    total_r    <= total_nxt;
    left_r     <= left_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_len_r  <= out_len_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_TDATA_W - CHAR_W - LEN_W)'(0), out_len_r, out_char_r};

endmodule

/* test/tb.sv */
// Self-checking testbench for the signed decimal ASCII emitter with stream driver and monitor.
module tb;
  import sdae_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_AT_VALUE = 40;
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_VALUES = 110;

  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              is_last;
    logic [LEN_W-1:0]  total_length;
  } text_char_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  logic [IN_TDATA_W-1:0] pending_values[$];
  text_char_t            expected_chars[$];
  int                    values_accepted = 0;
  int                    chars_seen = 0;
  int                    error_count = 0;
  int                    send_gap = 0;
  int                    recv_wait = 0;
  int                    hold_left = 0;
  logic                  hold_taken = 1'b0;
  int                    quiet_cycles = 0;

  signed_decimal_ascii_emitter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Appends the characters of one value's decimal text, sign first, digits most significant first.
  function automatic void push_decimal_text(input logic [IN_TDATA_W-1:0] raw);
    logic [VALUE_WIDTH-1:0] v;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   neg;
    logic [CHAR_W-1:0]      digits[$];
    int                     total;
    text_char_t             c;
    v = raw[VALUE_WIDTH-1:0];
    neg = v[VALUE_WIDTH-1];
    mag = neg ? (~v + 1'b1) : v;
    do begin
      digits.push_front(ASCII_ZERO + CHAR_W'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    while (digits.size() > MAX_CHARS) void'(digits.pop_back());
    total = digits.size() + (neg ? 1 : 0);
    if (total > MAX_CHARS) total = MAX_CHARS;
    if (neg) begin
      c.ascii_char = ASCII_MINUS;
      c.is_last = (total == 1);
      c.total_length = LEN_W'(total);
      expected_chars.push_back(c);
    end
    for (int i = 0; i < digits.size() && (i + (neg ? 1 : 0)) < total; i++) begin
      c.ascii_char = digits[i];
      c.is_last = ((i + (neg ? 1 : 0)) == total - 1);
      c.total_length = LEN_W'(total);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic logic [IN_TDATA_W-1:0] signed_of(input logic negate,
                                                      input logic [IN_TDATA_W-1:0] m);
    return negate ? (~m + 1'b1) : m;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        push_decimal_text(in_tdata);
        values_accepted <= values_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          in_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_values.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_values.pop_front();
          send_gap <= (((values_accepted / 25) % 2) == 1) ? $urandom_range(0, 15) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    int         w;
    text_char_t exp_c;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait <= 0;
    end else begin
      w = recv_wait;
      if (out_tvalid && out_tready) begin
        chars_seen <= chars_seen + 1;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected beat tdata=%h tlast=%b", out_tdata, out_tlast));
        end else begin
          exp_c = expected_chars.pop_front();
          if (out_tdata[7:0] !== exp_c.ascii_char)
            report_mismatch($sformatf("ascii_char %h, expected %h", out_tdata[7:0],
                                      exp_c.ascii_char));
          if (out_tdata[12:8] !== exp_c.total_length)
            report_mismatch($sformatf("total_length %0d, expected %0d", out_tdata[12:8],
                                      exp_c.total_length));
          if (out_tdata[15:13] !== 3'b000)
            report_mismatch($sformatf("padding bits %b, expected zero", out_tdata[15:13]));
          if (out_tlast !== exp_c.is_last)
            report_mismatch($sformatf("is_last %b, expected %b", out_tlast, exp_c.is_last));
        end
        w = (((chars_seen / 120) % 2) == 1) ? $urandom_range(0, 15) : 0;
      end else if (w != 0 && hold_left == 0) begin
        w = w - 1;
      end
      recv_wait <= w;
      out_tready <= (w == 0) && (hold_left == 0);
    end
  end

  // The receiver stalls once for a long stretch so that the block backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (!hold_taken && values_accepted == HOLD_AT_VALUE) begin
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without a beat", quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [IN_TDATA_W-1:0] m;
    logic [IN_TDATA_W-1:0] p;
    int                    kind;
    pending_values.push_back(64'd0);
    pending_values.push_back(64'd1);
    pending_values.push_back(-64'sd1);
    pending_values.push_back(64'd9);
    pending_values.push_back(64'd10);
    pending_values.push_back(-64'sd10);
    pending_values.push_back(64'd99);
    pending_values.push_back(64'd100);
    pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'h8000_0000_0000_0000);
    pending_values.push_back(64'h8000_0000_0000_0001);
    pending_values.push_back(64'd999_999_999_999_999_999);
    pending_values.push_back(64'd1_000_000_000_000_000_000);
    pending_values.push_back(-64'sd1_000_000_000_000_000_000);
    pending_values.push_back(64'd123_456_789);
    pending_values.push_back(-64'sd987_654_321);
    pending_values.push_back(64'h5555_5555_5555_5555);
    pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_values.push_back(64'd4_294_967_296);
    pending_values.push_back(-64'sd9);
    for (int n = 0; n < RANDOM_VALUES; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        m = {$urandom, $urandom};
        pending_values.push_back(m);
      end else if (kind < 8) begin
        m = {$urandom, $urandom} >> $urandom_range(1, 63);
        pending_values.push_back(signed_of(1'($urandom_range(0, 1)), m));
      end else begin
        p = 64'd1;
        repeat ($urandom_range(0, 18)) p = p * 10;
        m = p + $urandom_range(0, 2) - 1;
        pending_values.push_back(signed_of(1'($urandom_range(0, 1)), m));
      end
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_values.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0)
      report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
